@@ rtl/ohct_pkg.sv @@
// Package for the oriented hull collision test unit.
// CORDIC angle table, gain constant and shared types. No dependencies.
package ohct_pkg;

    localparam int ANGLE_ITERATIONS = 16;
    localparam int NSTEP = (ANGLE_ITERATIONS < 24) ? ANGLE_ITERATIONS : 24;
    localparam int VW = 32;
    localparam int QDEPTH = 4;
    localparam int QAW = 2;

    localparam logic [2:0] REG_POS_X   = 3'd0;
    localparam logic [2:0] REG_POS_Z   = 3'd1;
    localparam logic [2:0] REG_LENGTH  = 3'd2;
    localparam logic [2:0] REG_WIDTH   = 3'd3;
    localparam logic [2:0] REG_HEADING = 3'd4;

    function automatic logic [31:0] atan_turn(input int i);
        case (i)
            0: atan_turn = 32'h20000000;  1: atan_turn = 32'h12E4051E;
            2: atan_turn = 32'h09FB385B;  3: atan_turn = 32'h051111D4;
            4: atan_turn = 32'h028B0D43;  5: atan_turn = 32'h0145D7E1;
            6: atan_turn = 32'h00A2F61E;  7: atan_turn = 32'h00517C55;
            8: atan_turn = 32'h0028BE53;  9: atan_turn = 32'h00145F2F;
            10: atan_turn = 32'h000A2F98; 11: atan_turn = 32'h000517CC;
            12: atan_turn = 32'h00028BE6; 13: atan_turn = 32'h000145F3;
            14: atan_turn = 32'h0000A2FA; 15: atan_turn = 32'h0000517D;
            16: atan_turn = 32'h000028BE; 17: atan_turn = 32'h0000145F;
            18: atan_turn = 32'h00000A30; 19: atan_turn = 32'h00000518;
            20: atan_turn = 32'h0000028C; 21: atan_turn = 32'h00000146;
            22: atan_turn = 32'h000000A3; 23: atan_turn = 32'h00000051;
            default: atan_turn = 32'h0;
        endcase
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
        logic [63:0] n, r, b;
        n = n_in;
        r = 64'd0;
        b = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (b != 0 && b <= n_in) begin
                if (n >= r + b) begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] calc_gain();
        logic [63:0] g;
        g = 64'd1 << 60;
        for (int i = 0; i < NSTEP; i++) g = g + (g >> (2 * i));
        return (isqrt64(g) + (64'd1 << 13)) >> 14;
    endfunction

    localparam logic [63:0] GAIN_Q16 = calc_gain();
    localparam logic [17:0] GAIN = GAIN_Q16[17:0];

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic [15:0]          h_own;
        logic [15:0]          h_oth;
        logic [15:0]          own_len;
        logic [15:0]          own_wid;
        logic [15:0]          oth_len;
        logic [15:0]          oth_wid;
        logic [37:0]          dist2;
        logic                 near;
        logic                 last;
    } ohct_item_t;

endpackage

@@ rtl/ohct_front.sv @@
// Front end: difference, range check, distance squared and CORDIC input vector.
// Depends on ohct_pkg.
module ohct_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [31:0]  px,
    input  logic signed [31:0]  pz,
    input  logic [15:0]         olen,
    input  logic [15:0]         owid,
    input  logic [15:0]         ohead,
    input  logic                last,
    input  logic signed [31:0]  own_x,
    input  logic signed [31:0]  own_z,
    input  logic [15:0]         own_len,
    input  logic [15:0]         own_wid,
    input  logic [15:0]         own_head,
    output logic                out_valid,
    input  logic                out_ready,
    output ohct_pkg::ohct_item_t out_item
);
    import ohct_pkg::*;

    logic              v1_reg;
    logic signed [32:0] dx_reg, dz_reg;
    logic [15:0]       ol_reg, ow_reg, oh_reg, ml_reg, mw_reg, mh_reg;
    logic              last1_reg;
    logic              v2_reg;
    ohct_item_t        it_reg;

    logic              adv2, adv1;
    logic [32:0]       adx, adz;
    logic              near;
    logic signed [18:0] dxs, dzs;
    logic [37:0]       d2;
    ohct_item_t        it_next;

    assign adv2 = !v2_reg || out_ready;
    assign adv1 = !v1_reg || adv2;
    assign in_ready = adv1;
    assign out_valid = v2_reg;
    assign out_item = it_reg;

    always_comb begin
        adx = dx_reg[32] ? -dx_reg : dx_reg;
        adz = dz_reg[32] ? -dz_reg : dz_reg;
        near = (adx < 33'd262144) && (adz < 33'd262144);
        dxs = dx_reg[18:0];
        dzs = dz_reg[18:0];
        d2 = 38'(dxs * dxs) + 38'(dzs * dzs);
        it_next.near = near;
        it_next.dist2 = d2;
        if (d2 == 38'd0) begin
            it_next.x = 32'sd67108864;
            it_next.y = 32'sd0;
        end else begin
            it_next.x = {{5{dzs[18]}}, dzs, 8'd0};
            it_next.y = {{5{dxs[18]}}, dxs, 8'd0};
        end
        it_next.h_own = mh_reg;
        it_next.h_oth = oh_reg;
        it_next.own_len = ml_reg;
        it_next.own_wid = mw_reg;
        it_next.oth_len = ol_reg;
        it_next.oth_wid = ow_reg;
        it_next.last = last1_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= in_valid;
            if (adv2) v2_reg <= v1_reg;
        end
        if (adv1 && in_valid) begin
            dx_reg <= 33'(px) - 33'(own_x);
            dz_reg <= 33'(pz) - 33'(own_z);
            ol_reg <= olen; ow_reg <= owid; oh_reg <= ohead;
            ml_reg <= own_len; mw_reg <= own_wid; mh_reg <= own_head;
            last1_reg <= last;
        end
        if (adv2 && v1_reg) it_reg <= it_next;
    end
endmodule

@@ rtl/ohct_queue.sv @@
// Short FIFO between front and back ends.
// Depends on ohct_pkg.
module ohct_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ohct_pkg::ohct_item_t in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ohct_pkg::ohct_item_t out_item
);
    import ohct_pkg::*;

    ohct_item_t       mem [QDEPTH];
    logic [QAW-1:0]   wp_reg, rp_reg;
    logic [QAW:0]     cnt_reg;
    logic             wr, rd;

    assign in_ready = cnt_reg != QDEPTH[QAW:0];
    assign out_valid = cnt_reg != '0;
    assign out_item = mem[rp_reg];
    assign wr = in_valid && in_ready;
    assign rd = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr) wp_reg <= wp_reg + 1'b1;
            if (rd) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (QAW+1)'(wr) - (QAW+1)'(rd);
        end
        if (wr) mem[wp_reg] <= in_item;
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= QDEPTH[QAW:0]) else $error("queue overflow");
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == QDEPTH[QAW:0] && !rd) |=> !in_ready) else $error("full flag");
    a_cnt_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr && !rd) |=> cnt_reg == $past(cnt_reg) + 1'b1) else $error("count");
`endif
endmodule

@@ rtl/ohct_back.sv @@
// Back end: pipelined CORDIC for both headings, extent sum and compare.
// Depends on ohct_pkg.
module ohct_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ohct_pkg::ohct_item_t in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 hit,
    output logic                 last
);
    import ohct_pkg::*;

    localparam int NS = NSTEP + 4;

    typedef struct packed {
        logic signed [VW-1:0] x0, y0, x1, y1;
        logic signed [32:0]   z0, z1;
        logic [15:0]          l0, w0, l1, w1;
        logic [37:0]          d2;
        logic                 near, last;
        logic [47:0]          p0, p1, p2, p3;
        logic [49:0]          s;
        logic [63:0]          lhs;
    } st_t;

    st_t  st0;
    st_t  st_reg [1:NS];
    logic vld_reg [1:NS];
    logic adv;

    assign adv = !vld_reg[NS] || out_ready;
    assign in_ready = adv;
    assign out_valid = vld_reg[NS];
    assign hit = st_reg[NS].near && (st_reg[NS].lhs < {st_reg[NS].s[47:0], 16'd0});
    assign last = st_reg[NS].last;

    function automatic logic signed [VW-1:0] fshift(input logic signed [VW-1:0] v,
                                                    input int s);
        return v >>> s;
    endfunction

    always_comb begin : stage0
        logic [31:0] a0, a1;
        st0 = '0;
        a0 = 32'd0 - {in_item.h_own, 16'd0};
        a1 = 32'd0 - {in_item.h_oth, 16'd0};
        st0.x0 = in_item.x; st0.y0 = in_item.y;
        st0.x1 = in_item.x; st0.y1 = in_item.y;
        if (a0[31] ^ a0[30]) begin
            st0.x0 = -in_item.x; st0.y0 = -in_item.y;
            a0 = a0 + 32'h80000000;
        end
        if (a1[31] ^ a1[30]) begin
            st0.x1 = -in_item.x; st0.y1 = -in_item.y;
            a1 = a1 + 32'h80000000;
        end
        st0.z0 = {a0[31], a0};
        st0.z1 = {a1[31], a1};
        st0.l0 = in_item.own_len; st0.w0 = in_item.own_wid;
        st0.l1 = in_item.oth_len; st0.w1 = in_item.oth_wid;
        st0.d2 = in_item.dist2;
        st0.near = in_item.near;
        st0.last = in_item.last;
    end

    for (genvar g = 0; g < NS; g++) begin : g_stage
        st_t  src, nx;
        logic src_v;
        if (g == 0) begin : g_head
            assign src = st0;
            assign src_v = in_valid;
        end else begin : g_tail
            assign src = st_reg[g];
            assign src_v = vld_reg[g];
        end
        always_comb begin
            logic [63:0] ax;
            nx = src;
            if (g < NSTEP) begin
                if (!src.z0[32]) begin
                    nx.x0 = src.x0 - fshift(src.y0, g);
                    nx.y0 = src.y0 + fshift(src.x0, g);
                    nx.z0 = src.z0 - 33'(atan_turn(g));
                end else begin
                    nx.x0 = src.x0 + fshift(src.y0, g);
                    nx.y0 = src.y0 - fshift(src.x0, g);
                    nx.z0 = src.z0 + 33'(atan_turn(g));
                end
                if (!src.z1[32]) begin
                    nx.x1 = src.x1 - fshift(src.y1, g);
                    nx.y1 = src.y1 + fshift(src.x1, g);
                    nx.z1 = src.z1 - 33'(atan_turn(g));
                end else begin
                    nx.x1 = src.x1 + fshift(src.y1, g);
                    nx.y1 = src.y1 - fshift(src.x1, g);
                    nx.z1 = src.z1 + 33'(atan_turn(g));
                end
            end else if (g == NSTEP) begin
                nx.p0 = 48'(src.w0) * 48'(src.y0[VW-1] ? -src.y0 : src.y0);
                nx.p1 = 48'(src.l0) * 48'(src.x0[VW-1] ? -src.x0 : src.x0);
                nx.p2 = 48'(src.w1) * 48'(src.y1[VW-1] ? -src.y1 : src.y1);
                nx.p3 = 48'(src.l1) * 48'(src.x1[VW-1] ? -src.x1 : src.x1);
            end else if (g == NSTEP + 1) begin
                nx.s = 50'(src.p0) + 50'(src.p1);
                nx.p0 = src.p2 + src.p3;
                nx.lhs = 64'(src.d2) * 64'(GAIN);
            end else if (g == NSTEP + 2) begin
                nx.s = src.s + 50'(src.p0);
            end else begin
                ax = src.lhs << 9;
                nx.lhs = ax;
            end
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) vld_reg[g+1] <= 1'b0;
            else if (adv) vld_reg[g+1] <= src_v;
            if (adv) st_reg[g+1] <= nx;
        end
    end
endmodule

@@ rtl/oriented_hull_collision_test_unit.sv @@
// Oriented hull collision test, top level.
// Holds own ship registers; instantiates ohct_front, ohct_queue, ohct_back.
// Usage:
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes own ship
//   position, length, beam and heading; write only while idle.
//   s_ channel takes one object transaction per cycle; m_ channel returns
//   one transaction per object with object_hit and final_result, in order.
//   Throughput: one object per cycle unless m_ready stalls the pipeline,
//   set by the fully pipelined CORDIC (one rotation step per stage for
//   both headings in parallel). Pipeline: 2 front stages, 1 queue
//   register, ANGLE_ITERATIONS + 4 back stages.
//   A stalled receiver freezes the back pipeline; the 4-entry queue and the
//   front pipeline then fill and s_ready drops.
//   Synchronous active-low reset empties all stages and clears the registers.
module oriented_hull_collision_test_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_other_pos_x,
    input  logic signed [31:0] s_other_pos_z,
    input  logic [15:0]        s_other_length,
    input  logic [15:0]        s_other_width,
    input  logic [15:0]        s_other_heading,
    input  logic               s_final_object,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_object_hit,
    output logic               m_final_result
);
    import ohct_pkg::*;

    logic signed [31:0] px_reg, pz_reg;
    logic [15:0]        len_reg, wid_reg, head_reg;
    logic               fv, fr, qv, qr;
    ohct_item_t         fi, qi;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            px_reg <= '0; pz_reg <= '0; len_reg <= '0; wid_reg <= '0; head_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_POS_X:   px_reg <= cfg_data;
                REG_POS_Z:   pz_reg <= cfg_data;
                REG_LENGTH:  len_reg <= cfg_data[15:0];
                REG_WIDTH:   wid_reg <= cfg_data[15:0];
                REG_HEADING: head_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    ohct_front u_front (
        .aclk, .aresetn, .in_valid(s_valid), .in_ready(s_ready),
        .px(s_other_pos_x), .pz(s_other_pos_z), .olen(s_other_length),
        .owid(s_other_width), .ohead(s_other_heading), .last(s_final_object),
        .own_x(px_reg), .own_z(pz_reg), .own_len(len_reg), .own_wid(wid_reg),
        .own_head(head_reg), .out_valid(fv), .out_ready(fr), .out_item(fi)
    );

    ohct_queue u_queue (
        .aclk, .aresetn, .in_valid(fv), .in_ready(fr), .in_item(fi),
        .out_valid(qv), .out_ready(qr), .out_item(qi)
    );

    ohct_back u_back (
        .aclk, .aresetn, .in_valid(qv), .in_ready(qr), .in_item(qi),
        .out_valid(m_valid), .out_ready(m_ready), .hit(m_object_hit),
        .last(m_final_result)
    );
endmodule

@@ verif/oriented_hull_collision_test_unit_test.sv @@
// Testbench for oriented_hull_collision_test_unit: directed and random object
// streams checked against an in-bench CORDIC hull-extent predictor.
// Depends on rtl/ohct_pkg.sv and rtl/oriented_hull_collision_test_unit.sv.
`timescale 1ns / 1ps

class hit_scoreboard;
    bit exp_hit[$];
    bit exp_last[$];
    int errors;

    function void note_object(bit hit, bit last);
        exp_hit = {exp_hit, hit};
        exp_last = {exp_last, last};
    endfunction

    function int pending();
        return exp_hit.size();
    endfunction

    // returns a short description of any mismatch, empty if it matched
    function string check_result(bit hit, bit last);
        bit eh, el;
        if (exp_hit.size() == 0) return "result with no pending object";
        eh = exp_hit.pop_front();
        el = exp_last.pop_front();
        if (eh != hit) return $sformatf("object_hit %0d expected %0d", hit, eh);
        if (el != last) return $sformatf("final_result %0d expected %0d", last, el);
        return "";
    endfunction
endclass

module oriented_hull_collision_test_unit_test;
    import ohct_pkg::*;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [31:0] s_other_pos_x = '0;
    logic signed [31:0] s_other_pos_z = '0;
    logic [15:0] s_other_length = '0;
    logic [15:0] s_other_width = '0;
    logic [15:0] s_other_heading = '0;
    logic s_final_object = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_object_hit;
    logic m_final_result;

    oriented_hull_collision_test_unit dut (.*);

    always #1 aclk = ~aclk;

    hit_scoreboard sb = new();
    int fail_count = 0;

    int send_idle_pct = 31;
    int recv_idle_pct = 84;
    bit hold_recv = 1'b0;

    logic signed [31:0] own_x = 0, own_z = 0;
    logic [15:0] own_len = 0, own_wid = 0, own_head = 0;

    localparam int STEPS = (ANGLE_ITERATIONS < 24) ? ANGLE_ITERATIONS : 24;
    localparam int LAT = 30;
    localparam logic [2:0] REG_SPARE_A = 3'd5;
    localparam logic [2:0] REG_SPARE_B = 3'd7;

    function automatic longint atan_of(int i);
        logic [31:0] t [24] = '{
            32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
            32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
            32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
            32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
            32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
            32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
        return longint'(t[i]);
    endfunction

    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned cordic_gain();
        longint unsigned g;
        g = 64'd1 << 60;
        for (int i = 0; i < STEPS; i++) g += g >> (2 * i);
        return (root_floor(g) + (64'd1 << 13)) >> 14;
    endfunction

    function automatic longint absl(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint unsigned hull_extent(longint x, longint y,
            logic [15:0] head, logic [15:0] len, logic [15:0] wid);
        logic [31:0] a;
        longint z, nx, ny;
        a = 32'd0 - {head, 16'd0};
        if (((a + 32'h40000000) & 32'h80000000) != 0) begin
            x = -x;
            y = -y;
            a += 32'h80000000;
        end
        z = longint'($signed(a));
        for (int i = 0; i < STEPS; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z -= atan_of(i);
            end else begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z += atan_of(i);
            end
            x = nx;
            y = ny;
        end
        return longint'(wid) * absl(y) + longint'(len) * absl(x);
    endfunction

    function automatic bit predict_hit(logic signed [31:0] px, logic signed [31:0] pz,
            logic [15:0] len, logic [15:0] wid, logic [15:0] head);
        longint dx, dz, vx, vy;
        longint unsigned d2, s, lhs;
        dx = longint'(px) - longint'(own_x);
        dz = longint'(pz) - longint'(own_z);
        if (absl(dx) >= (64'sd1 << 18) || absl(dz) >= (64'sd1 << 18)) return 1'b0;
        d2 = dx * dx + dz * dz;
        if (d2 == 0) begin
            vx = 64'sd1 << 26;
            vy = 0;
        end else begin
            vx = dz * 256;
            vy = dx * 256;
        end
        s = hull_extent(vx, vy, own_head, own_len, own_wid)
          + hull_extent(vx, vy, head, len, wid);
        lhs = 2 * d2 * cordic_gain() * 256;
        return lhs < (s << 16);
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_POS_X: own_x = val;
            REG_POS_Z: own_z = val;
            REG_LENGTH: own_len = val[15:0];
            REG_WIDTH: own_wid = val[15:0];
            REG_HEADING: own_head = val[15:0];
            default: ;
        endcase
    endtask

    task automatic set_own(logic [31:0] x, logic [31:0] z, logic [15:0] l,
            logic [15:0] w, logic [15:0] h);
        write_reg(REG_POS_X, x);
        write_reg(REG_POS_Z, z);
        write_reg(REG_LENGTH, {16'd0, l});
        write_reg(REG_WIDTH, {16'd0, w});
        write_reg(REG_HEADING, {16'd0, h});
        cfg_valid <= 1'b0;
    endtask

    task automatic send_object(logic signed [31:0] px, logic signed [31:0] pz,
            logic [15:0] l, logic [15:0] w, logic [15:0] h, bit last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_other_pos_x <= px;
        s_other_pos_z <= pz;
        s_other_length <= l;
        s_other_width <= w;
        s_other_heading <= h;
        s_final_object <= last;
        do @(posedge aclk); while (!s_ready);
        sb.note_object(predict_hit(px, pz, l, w, h), last);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (LAT) @(posedge aclk);
    endtask

    task automatic random_object();
        logic signed [31:0] px, pz;
        logic [15:0] l, w;
        int mode;
        mode = $urandom_range(9);
        if (mode < 7) begin
            px = own_x + $signed($urandom_range(8000)) - 4000;
            pz = own_z + $signed($urandom_range(8000)) - 4000;
        end else if (mode == 7) begin
            px = own_x + $signed($urandom_range(1 << 19)) - (1 << 18);
            pz = own_z + $signed($urandom_range(1 << 19)) - (1 << 18);
        end else begin
            px = $urandom();
            pz = $urandom();
        end
        if ($urandom_range(5) == 0) begin
            l = '0;
            w = '0;
        end else if ($urandom_range(5) == 0) begin
            l = 16'($urandom());
            w = 16'($urandom());
        end else begin
            l = 16'($urandom_range(3000));
            w = 16'($urandom_range(800));
        end
        send_object(px, pz, l, w, 16'($urandom()), $urandom_range(7) == 0);
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                string r;
                r = sb.check_result(m_object_hit, m_final_result);
                if (r != "") report_mismatch(r);
            end
            m_ready <= !hold_recv && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset config: zero-size own ship at origin
        send_object(0, 0, 0, 0, 0, 1'b0);
        send_object(0, 0, 100, 0, 0, 1'b1);
        drain();
        set_own(32'h7FFF_FFF0, 32'h8000_0010, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_object(32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0);
        send_object(32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        send_object(32'h7FFF_FFF0 + (1 << 18), 32'h8000_0010, 1, 1, 0, 1'b0);
        send_object(32'h7FFF_FFF0 - (1 << 18) + 1, 32'h8000_0010, 1, 1, 0, 1'b1);
        drain();
        set_own(0, 0, 1600, 400, 16'h4000);
        send_object(0, 0, 0, 0, 0, 1'b0);
        send_object(0, 800, 0, 0, 16'h8000, 1'b0);
        send_object(800, 0, 0, 0, 0, 1'b0);
        send_object(801, 0, 0, 0, 0, 1'b0);
        send_object(0, 210, 0, 0, 0, 1'b0);
        send_object(0, 190, 0, 0, 0, 1'b0);
        send_object(1500, 1500, 1600, 400, 16'h2000, 1'b0);
        send_object(-1000, -300, 2000, 500, 16'hC000, 1'b0);
        send_object(-(1 << 18) + 1, (1 << 18) - 1, 16'hFFFF, 16'hFFFF, 16'h7FFF, 1'b1);
        drain();
        write_reg(REG_SPARE_A, 32'hDEAD_BEEF);
        write_reg(REG_SPARE_B, 32'h1234_5678);
        cfg_valid <= 1'b0;
        send_object(300, 300, 1000, 1000, 16'h1234, 1'b1);
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 84 : 0;
            recv_idle_pct = (phase == 0) ? 84 : (phase == 1) ? 31 : 0;
            for (int c = 0; c < 5; c++) begin
                set_own($urandom(), $urandom(),
                        (c == 0) ? 16'hFFFF : 16'($urandom_range(3000)),
                        (c == 0) ? 16'hFFFF : 16'($urandom_range(800)),
                        16'($urandom()));
                if (phase == 2 && c == 2) begin
                    fork
                        begin
                            hold_recv = 1'b1;
                            repeat (200) @(posedge aclk);
                            hold_recv = 1'b0;
                        end
                    join_none
                end
                for (int n = 0; n < 115; n++) random_object();
                drain();
            end
        end

        if (fail_count == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end
endmodule
